>>> hdl/baro_sensor_compensation_macros.svh
// Assertion macros for the barometric compensation checker.
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define BARO_ASSERT_IMP(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("baro compensation check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define BARO_ASSERT_NXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("baro compensation check failed");

`endif

>>> hdl/baro_pkg.sv
// Types, register indexes and constants for the barometric compensation block.
package baro_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TEMP_W    = 15;
    localparam int PRES_W    = 17;

    // Calibration register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMP         = 3'd4,
        REG_TEMP_SENSITIVITY       = 3'd5
    } cal_reg_t;

    localparam logic [CAL_W-1:0] C1_RESET = 16'd40127;
    localparam logic [CAL_W-1:0] C2_RESET = 16'd36924;
    localparam logic [CAL_W-1:0] C3_RESET = 16'd23317;
    localparam logic [CAL_W-1:0] C4_RESET = 16'd23282;
    localparam logic [CAL_W-1:0] C5_RESET = 16'd33464;
    localparam logic [CAL_W-1:0] C6_RESET = 16'd28312;

    // 20.00 degC pivot and output ranges
    localparam int TEMP_REF = 2000;
    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;
    localparam int PRES_MIN = 1000;
    localparam int PRES_MAX = 120000;

    typedef struct packed {
        logic [CAL_W-1:0] c1;   // pressure sensitivity
        logic [CAL_W-1:0] c2;   // pressure offset
        logic [CAL_W-1:0] c3;   // temperature coefficient of sensitivity
        logic [CAL_W-1:0] c4;   // temperature coefficient of offset
        logic [CAL_W-1:0] c5;   // reference temperature / 256
        logic [CAL_W-1:0] c6;   // temperature coefficient of temperature
    } cal_t;

endpackage

>>> hdl/baro_cal_regs.sv
// Calibration word register file with a plain write port.
module baro_cal_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [baro_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [baro_pkg::CAL_W-1:0]       cfg_data,
    output baro_pkg::cal_t                   cal
);

    baro_pkg::cal_t cal_reg;
    baro_pkg::cal_t cal_next;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                baro_pkg::REG_PRESSURE_SENSITIVITY:   cal_next.c1 = cfg_data;
                baro_pkg::REG_PRESSURE_OFFSET:        cal_next.c2 = cfg_data;
                baro_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_next.c3 = cfg_data;
                baro_pkg::REG_OFFSET_TEMP_COEFF:      cal_next.c4 = cfg_data;
                baro_pkg::REG_REFERENCE_TEMP:         cal_next.c5 = cfg_data;
                baro_pkg::REG_TEMP_SENSITIVITY:       cal_next.c6 = cfg_data;
                default:                              cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.c1 <= baro_pkg::C1_RESET;
            cal_reg.c2 <= baro_pkg::C2_RESET;
            cal_reg.c3 <= baro_pkg::C3_RESET;
            cal_reg.c4 <= baro_pkg::C4_RESET;
            cal_reg.c5 <= baro_pkg::C5_RESET;
            cal_reg.c6 <= baro_pkg::C6_RESET;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

>>> hdl/baro_sensor_compensation.sv
// Top level: nine-stage second-order barometric pressure and temperature compensation.
//
// Takes one raw pressure/temperature conversion pair per beat and returns one
// compensated result per beat: temperature in 0.01 degC (-4000..8500) and
// pressure in 0.01 mbar (1000..120000), both saturated, with clamped set when
// either was limited. The pipeline is nine register stages deep, and a new beat
// is taken every cycle while nothing stalls. Stages fill bubbles independently,
// so the input keeps flowing while a result waits at the output until the
// pipeline is full.
// The depth is set by the multiplier chain: dT products, the squared deviation,
// and the 24 x 37 bit pressure product split into partial products and a sum.
// Calibration words are written through the plain write port and reset to the
// factory defaults. The user must write them only while idle; the block does not enforce it.
module baro_sensor_compensation
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [baro_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [baro_pkg::CAL_W-1:0]           cfg_data,
    input  logic                                 raw_valid,
    output logic                                 raw_stall,
    input  logic [baro_pkg::RAW_W-1:0]           raw_pressure,
    input  logic [baro_pkg::RAW_W-1:0]           raw_temperature,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [baro_pkg::TEMP_W-1:0]   temperature_centideg,
    output logic [baro_pkg::PRES_W-1:0]          pressure_centimbar,
    output logic                                 clamped
);

    localparam int STAGES = 9;

    baro_pkg::cal_t cal;

    baro_cal_regs u_cal_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // ---------------------------------------------------------------- control
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] adv;

    // A stage loads when it is empty or the one after it moves on
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= raw_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign raw_stall    = !adv[0];
    assign result_valid = valid_reg[STAGES-1];

    // ---------------------------------------------------------------- stage 1: dT
    logic [23:0]        d1_s1_reg;
    logic signed [24:0] dt_s1_reg;
    logic signed [24:0] dt_s1_next;

    assign dt_s1_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});

    // ---------------------------------------------------------------- stage 2: dT products
    logic [23:0]        d1_s2_reg;
    logic signed [40:0] mt_s2_reg;
    logic signed [40:0] mo_s2_reg;
    logic signed [40:0] ms_s2_reg;
    logic signed [48:0] mdd_s2_reg;
    logic signed [40:0] mt_s2_next;
    logic signed [40:0] mo_s2_next;
    logic signed [40:0] ms_s2_next;
    logic signed [48:0] mdd_s2_next;

    assign mt_s2_next  = dt_s1_reg * $signed({1'b0, cal.c6});
    assign mo_s2_next  = dt_s1_reg * $signed({1'b0, cal.c4});
    assign ms_s2_next  = dt_s1_reg * $signed({1'b0, cal.c3});
    assign mdd_s2_next = dt_s1_reg * dt_s1_reg;

    // ---------------------------------------------------------------- stage 3: first order
    logic [23:0]        d1_s3_reg;
    logic signed [17:0] dev_s3_reg;
    logic [18:0]        temp1_s3_reg;
    logic [34:0]        off1_s3_reg;
    logic [33:0]        sens1_s3_reg;
    logic [17:0]        t2_s3_reg;
    logic               cold_s3_reg;
    logic [18:0]        temp1_s3_next;
    logic [34:0]        off1_s3_next;
    logic [33:0]        sens1_s3_next;

    // Arithmetic shifts are taken as the upper bits, which floors
    assign temp1_s3_next = {mt_s2_reg[40], mt_s2_reg[40:23]} + 19'(baro_pkg::TEMP_REF);
    assign off1_s3_next  = {3'b000, cal.c2, 16'd0} + {mo_s2_reg[40], mo_s2_reg[40:7]};
    assign sens1_s3_next = {2'b00, cal.c1, 15'd0} + {ms_s2_reg[40], ms_s2_reg[40:8]};

    // ---------------------------------------------------------------- stage 4: squared deviation
    logic [23:0]        d1_s4_reg;
    logic [18:0]        temp1_s4_reg;
    logic [34:0]        off1_s4_reg;
    logic [33:0]        sens1_s4_reg;
    logic [17:0]        t2_s4_reg;
    logic               cold_s4_reg;
    logic [34:0]        sq_s4_reg;
    logic signed [35:0] sq_full;

    assign sq_full = dev_s3_reg * dev_s3_reg;

    // ---------------------------------------------------------------- stage 5: second order
    logic [23:0] d1_s5_reg;
    logic [19:0] temp_s5_reg;
    logic [37:0] off_s5_reg;
    logic [36:0] sens_s5_reg;
    logic [37:0] five_sq;
    logic [19:0] temp_s5_next;
    logic [37:0] off_s5_next;
    logic [36:0] sens_s5_next;

    always_comb
    begin
        five_sq      = {3'b000, sq_s4_reg} + {1'b0, sq_s4_reg, 2'b00};
        temp_s5_next = {temp1_s4_reg[18], temp1_s4_reg};
        off_s5_next  = {{3{off1_s4_reg[34]}}, off1_s4_reg};
        sens_s5_next = {{3{sens1_s4_reg[33]}}, sens1_s4_reg};
        if (cold_s4_reg)
        begin
            temp_s5_next = temp_s5_next - {2'b00, t2_s4_reg};
            off_s5_next  = off_s5_next - {1'b0, five_sq[37:1]};
            sens_s5_next = sens_s5_next - {1'b0, five_sq[37:2]};
        end
    end

    // ---------------------------------------------------------------- stage 6: partial products
    logic [19:0]        temp_s6_reg;
    logic [37:0]        off_s6_reg;
    logic [41:0]        plo_s6_reg;
    logic signed [43:0] phi_s6_reg;
    logic [41:0]        plo_s6_next;
    logic signed [43:0] phi_s6_next;

    assign plo_s6_next = {18'd0, d1_s5_reg} * {24'd0, sens_s5_reg[17:0]};
    assign phi_s6_next = $signed({1'b0, d1_s5_reg}) * $signed(sens_s5_reg[36:18]);

    // ---------------------------------------------------------------- stage 7: product sum
    logic [19:0] temp_s7_reg;
    logic [37:0] off_s7_reg;
    logic [61:0] prod_s7_reg;
    logic [61:0] prod_s7_next;

    assign prod_s7_next = {phi_s6_reg, 18'd0} + {20'd0, plo_s6_reg};

    // ---------------------------------------------------------------- stage 8: offset, temp limit
    logic [41:0]                  diff_s8_reg;
    logic [baro_pkg::TEMP_W-1:0]  temp_s8_reg;
    logic                         tclamp_s8_reg;
    logic [41:0]                  diff_s8_next;
    logic [baro_pkg::TEMP_W-1:0]  temp_s8_next;
    logic                         tclamp_s8_next;
    logic                         temp_low;
    logic                         temp_high;

    always_comb
    begin
        diff_s8_next = {prod_s7_reg[61], prod_s7_reg[61:21]} - {{4{off_s7_reg[37]}}, off_s7_reg};
        temp_low     = $signed(temp_s7_reg) < baro_pkg::TEMP_MIN;
        temp_high    = $signed(temp_s7_reg) > baro_pkg::TEMP_MAX;
        tclamp_s8_next = temp_low || temp_high;
        if (temp_low)
        begin
            temp_s8_next = baro_pkg::TEMP_W'(baro_pkg::TEMP_MIN);
        end
        else if (temp_high)
        begin
            temp_s8_next = baro_pkg::TEMP_W'(baro_pkg::TEMP_MAX);
        end
        else
        begin
            temp_s8_next = temp_s7_reg[baro_pkg::TEMP_W-1:0];
        end
    end

    // ---------------------------------------------------------------- stage 9: pressure limit
    logic signed [baro_pkg::TEMP_W-1:0] temp_out_reg;
    logic [baro_pkg::PRES_W-1:0]        pres_out_reg;
    logic                               clamped_out_reg;
    logic [26:0]                        pres_raw;
    logic                               pres_low;
    logic                               pres_high;
    logic [baro_pkg::PRES_W-1:0]        pres_out_next;

    always_comb
    begin
        pres_raw  = diff_s8_reg[41:15];
        pres_low  = $signed(pres_raw) < baro_pkg::PRES_MIN;
        pres_high = $signed(pres_raw) > baro_pkg::PRES_MAX;
        if (pres_low)
        begin
            pres_out_next = baro_pkg::PRES_W'(baro_pkg::PRES_MIN);
        end
        else if (pres_high)
        begin
            pres_out_next = baro_pkg::PRES_W'(baro_pkg::PRES_MAX);
        end
        else
        begin
            pres_out_next = pres_raw[baro_pkg::PRES_W-1:0];
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s1_reg <= raw_pressure;
            dt_s1_reg <= dt_s1_next;
        end
        if (adv[1])
        begin
            d1_s2_reg  <= d1_s1_reg;
            mt_s2_reg  <= mt_s2_next;
            mo_s2_reg  <= mo_s2_next;
            ms_s2_reg  <= ms_s2_next;
            mdd_s2_reg <= mdd_s2_next;
        end
        if (adv[2])
        begin
            d1_s3_reg    <= d1_s2_reg;
            dev_s3_reg   <= mt_s2_reg[40:23];
            temp1_s3_reg <= temp1_s3_next;
            off1_s3_reg  <= off1_s3_next;
            sens1_s3_reg <= sens1_s3_next;
            t2_s3_reg    <= mdd_s2_reg[48:31];
            cold_s3_reg  <= mt_s2_reg[40];
        end
        if (adv[3])
        begin
            d1_s4_reg    <= d1_s3_reg;
            temp1_s4_reg <= temp1_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            t2_s4_reg    <= t2_s3_reg;
            cold_s4_reg  <= cold_s3_reg;
            sq_s4_reg    <= sq_full[34:0];
        end
        if (adv[4])
        begin
            d1_s5_reg   <= d1_s4_reg;
            temp_s5_reg <= temp_s5_next;
            off_s5_reg  <= off_s5_next;
            sens_s5_reg <= sens_s5_next;
        end
        if (adv[5])
        begin
            temp_s6_reg <= temp_s5_reg;
            off_s6_reg  <= off_s5_reg;
            plo_s6_reg  <= plo_s6_next;
            phi_s6_reg  <= phi_s6_next;
        end
        if (adv[6])
        begin
            temp_s7_reg <= temp_s6_reg;
            off_s7_reg  <= off_s6_reg;
            prod_s7_reg <= prod_s7_next;
        end
        if (adv[7])
        begin
            diff_s8_reg   <= diff_s8_next;
            temp_s8_reg   <= temp_s8_next;
            tclamp_s8_reg <= tclamp_s8_next;
        end
        if (adv[8])
        begin
            temp_out_reg    <= temp_s8_reg;
            pres_out_reg    <= pres_out_next;
            clamped_out_reg <= tclamp_s8_reg || pres_low || pres_high;
        end
    end

    assign temperature_centideg = temp_out_reg;
    assign pressure_centimbar   = pres_out_reg;
    assign clamped              = clamped_out_reg;

endmodule

>>> hdl/baro_sensor_compensation_checker.sv
// Port-level checker for the barometric compensation block, with its bind.
`include "baro_sensor_compensation_macros.svh"

module baro_sensor_compensation_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 raw_valid,
    input logic                                 raw_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic signed [baro_pkg::TEMP_W-1:0]   temperature_centideg,
    input logic [baro_pkg::PRES_W-1:0]          pressure_centimbar,
    input logic                                 clamped
);

    logic temp_in_range;
    logic pres_in_range;
    logic temp_inside;
    logic pres_inside;

    assign temp_in_range = (temperature_centideg >= baro_pkg::TEMP_MIN) &&
                           (temperature_centideg <= baro_pkg::TEMP_MAX);
    assign pres_in_range = (pressure_centimbar >= baro_pkg::PRES_MIN) &&
                           (pressure_centimbar <= baro_pkg::PRES_MAX);
    // Strictly inside both ranges: no limit can have been applied
    assign temp_inside   = (temperature_centideg > baro_pkg::TEMP_MIN) &&
                           (temperature_centideg < baro_pkg::TEMP_MAX);
    assign pres_inside   = (pressure_centimbar > baro_pkg::PRES_MIN) &&
                           (pressure_centimbar < baro_pkg::PRES_MAX);

    `BARO_ASSERT_IMP(a_result_in_range, result_valid, temp_in_range && pres_in_range)
    `BARO_ASSERT_IMP(a_no_clamp_inside, result_valid && temp_inside && pres_inside, !clamped)
    `BARO_ASSERT_IMP(a_no_stall_when_drained, !result_valid, !raw_stall)
    `BARO_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid && $stable(temperature_centideg) && $stable(pressure_centimbar) && $stable(clamped))
    // A stalled input beat stays offered until it is taken
    `BARO_ASSERT_NXT(a_input_held, raw_valid && raw_stall, raw_valid)

endmodule

bind baro_sensor_compensation baro_sensor_compensation_checker u_checker (.*);

>>> tb/testbench.sv
// Self-checking baro compensation bench: directed and random beats, predicted readings.
`timescale 1ns / 1ps

module testbench;
    import baro_pkg::*;

    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;
    localparam int RAW_MAX        = 16777215;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0] T_PIVOT = {C5_RESET, 8'h00};

    typedef struct packed {
        logic [RAW_W-1:0] pressure;
        logic [RAW_W-1:0] temperature;
    } raw_pair_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
        logic                     clamped;
    } reading_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CAL_W-1:0]           cfg_data = '0;
    logic                       raw_valid = 1'b0;
    logic                       raw_stall;
    logic [RAW_W-1:0]           raw_pressure = '0;
    logic [RAW_W-1:0]           raw_temperature = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [TEMP_W-1:0]   temperature_centideg;
    logic [PRES_W-1:0]          pressure_centimbar;
    logic                       clamped;

    raw_pair_t pending_pairs[$];
    reading_t  expected_readings[$];
    cal_t      cal_model = '{c1: C1_RESET, c2: C2_RESET, c3: C3_RESET,
                             c4: C4_RESET, c5: C5_RESET, c6: C6_RESET};
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    baro_sensor_compensation u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .raw_valid            (raw_valid),
        .raw_stall            (raw_stall),
        .raw_pressure         (raw_pressure),
        .raw_temperature      (raw_temperature),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .temperature_centideg (temperature_centideg),
        .pressure_centimbar   (pressure_centimbar),
        .clamped              (clamped)
    );

    always #6 clk = ~clk;

    // Second-order compensation of one conversion pair, floor shifts throughout
    function automatic reading_t compensate(logic [RAW_W-1:0] d1_raw, logic [RAW_W-1:0] d2_raw);
        longint d1, d2, dt, temp, off, sens, p, dev, sq;
        longint c1, c2, c3, c4, c5, c6;
        reading_t r;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal_model.c1);
        c2 = longint'(cal_model.c2);
        c3 = longint'(cal_model.c3);
        c4 = longint'(cal_model.c4);
        c5 = longint'(cal_model.c5);
        c6 = longint'(cal_model.c6);
        dt   = d2 - c5 * 256;
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        if (temp < TEMP_REF)
        begin
            dev  = temp - TEMP_REF;
            sq   = dev * dev;
            temp = temp - ((dt * dt) >>> 31);
            off  = off - ((5 * sq) >>> 1);
            sens = sens - ((5 * sq) >>> 2);
        end
        p = ((((d1 * sens) >>> 21) - off) >>> 15);
        r.clamped = 1'b0;
        if (temp < TEMP_MIN)
        begin
            temp = longint'(TEMP_MIN);
            r.clamped = 1'b1;
        end
        if (temp > TEMP_MAX)
        begin
            temp = longint'(TEMP_MAX);
            r.clamped = 1'b1;
        end
        if (p < PRES_MIN)
        begin
            p = longint'(PRES_MIN);
            r.clamped = 1'b1;
        end
        if (p > PRES_MAX)
        begin
            p = longint'(PRES_MAX);
            r.clamped = 1'b1;
        end
        r.temp = temp[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    // Temperatures mostly near the reference, pressures half plausible, the rest noise
    function automatic raw_pair_t random_pair();
        int t;
        raw_pair_t pair;
        if ($urandom_range(3) == 0)
            pair.temperature = RAW_W'($urandom_range(RAW_MAX));
        else
        begin
            t = int'({cal_model.c5, 8'h00}) + int'($urandom_range(4194304)) - 2097152;
            if (t < 0)
                t = 0;
            if (t > RAW_MAX)
                t = RAW_MAX;
            pair.temperature = t[RAW_W-1:0];
        end
        if ($urandom_range(1) == 0)
            pair.pressure = RAW_W'($urandom_range(RAW_MAX));
        else
            pair.pressure = RAW_W'($urandom_range(11000000, 3000000));
        return pair;
    endfunction

    function automatic cal_t near_default_cal();
        cal_t c;
        c.c1 = CAL_W'(int'(C1_RESET) + int'($urandom_range(8000)) - 4000);
        c.c2 = CAL_W'(int'(C2_RESET) + int'($urandom_range(8000)) - 4000);
        c.c3 = CAL_W'(int'(C3_RESET) + int'($urandom_range(8000)) - 4000);
        c.c4 = CAL_W'(int'(C4_RESET) + int'($urandom_range(8000)) - 4000);
        c.c5 = CAL_W'(int'(C5_RESET) + int'($urandom_range(8000)) - 4000);
        c.c6 = CAL_W'(int'(C6_RESET) + int'($urandom_range(8000)) - 4000);
        return c;
    endfunction

    task automatic report_mismatch(string what);
        // Print the first few, count all
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PRESSURE_SENSITIVITY:   cal_model.c1 = val;
            REG_PRESSURE_OFFSET:        cal_model.c2 = val;
            REG_SENSITIVITY_TEMP_COEFF: cal_model.c3 = val;
            REG_OFFSET_TEMP_COEFF:      cal_model.c4 = val;
            REG_REFERENCE_TEMP:         cal_model.c5 = val;
            REG_TEMP_SENSITIVITY:       cal_model.c6 = val;
            default: ;
        endcase
    endtask

    task automatic load_calibration(cal_t c, bit with_spare);
        write_reg(REG_PRESSURE_SENSITIVITY, c.c1);
        write_reg(REG_PRESSURE_OFFSET, c.c2);
        if (with_spare)
            write_reg(REG_SPARE_LO, CAL_W'($urandom_range(65535)));
        write_reg(REG_SENSITIVITY_TEMP_COEFF, c.c3);
        write_reg(REG_OFFSET_TEMP_COEFF, c.c4);
        write_reg(REG_REFERENCE_TEMP, c.c5);
        if (with_spare)
            write_reg(REG_SPARE_HI, CAL_W'($urandom_range(65535)));
        write_reg(REG_TEMP_SENSITIVITY, c.c6);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || raw_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(int count, int s_idle, int r_idle);
        @(negedge clk);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count) pending_pairs.push_back(random_pair());
        wait_drained();
    endtask

    // Sender: hold a stalled beat, otherwise offer the next pair or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid <= 1'b0;
        end
        else
        begin
            if (raw_valid && !raw_stall)
            begin
                expected_readings.push_back(compensate(raw_pressure, raw_temperature));
                void'(pending_pairs.pop_front());
            end
            if (!raw_valid || !raw_stall)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    raw_valid       <= 1'b1;
                    raw_pressure    <= pending_pairs[0].pressure;
                    raw_temperature <= pending_pairs[0].temperature;
                end
                else
                    raw_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each accepted beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = expected_readings.pop_front();
                    if (temperature_centideg !== want.temp)
                        report_mismatch($sformatf("temperature %0d, expected %0d",
                                                  temperature_centideg, want.temp));
                    if (pressure_centimbar !== want.pres)
                        report_mismatch($sformatf("pressure %0d, expected %0d",
                                                  pressure_centimbar, want.pres));
                    if (clamped !== want.clamped)
                        report_mismatch($sformatf("clamped %b, expected %b",
                                                  clamped, want.clamped));
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (raw_valid && !raw_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset calibration
        @(negedge clk);
        send_idle_pct = 30;
        recv_idle_pct = 67;
        pending_pairs.push_back('{pressure: 24'd0, temperature: 24'd0});
        pending_pairs.push_back('{pressure: 24'hFFFFFF, temperature: 24'hFFFFFF});
        pending_pairs.push_back('{pressure: 24'd0, temperature: 24'hFFFFFF});
        pending_pairs.push_back('{pressure: 24'hFFFFFF, temperature: 24'd0});
        // exactly 20 degC, one step either side of it, and a typical reading
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT - 24'd1});
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT + 24'd1});
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: 24'd8569150});
        // very cold, still in range, then far below the range
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT - 24'd1200000});
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT - 24'd3000000});
        // either side of 85 degC
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT + 24'd1925000});
        pending_pairs.push_back('{pressure: 24'd9085466, temperature: T_PIVOT + 24'd1927000});
        // pressure at and around both ends of its range
        pending_pairs.push_back('{pressure: 24'd0, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'hFFFFFF, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'd3911000, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'd3913000, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'd10130000, temperature: T_PIVOT});
        pending_pairs.push_back('{pressure: 24'd10132000, temperature: T_PIVOT});
        run_phase(150, 30, 67);

        load_calibration('{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                           c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF}, 1'b1);
        run_phase(40, 30, 67);

        load_calibration('0, 1'b1);
        run_phase(40, 67, 30);

        load_calibration(cal_t'({$urandom(), $urandom(), $urandom()}), 1'b0);
        run_phase(120, 67, 30);

        load_calibration('{c1: C1_RESET, c2: C2_RESET, c3: C3_RESET,
                           c4: C4_RESET, c5: C5_RESET, c6: C6_RESET}, 1'b1);
        run_phase(200, 67, 30);

        load_calibration(near_default_cal(), 1'b0);
        run_phase(150, 0, 0);

        load_calibration(near_default_cal(), 1'b1);
        run_phase(150, 0, 0);

        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> baro_sensor_compensation.f
+incdir+hdl
hdl/baro_pkg.sv
hdl/baro_cal_regs.sv
hdl/baro_sensor_compensation.sv
hdl/baro_sensor_compensation_checker.sv
tb/testbench.sv
